@@ rtl/core/mbl_pkg.sv @@
// mbl_pkg: shared widths, constants, register codes and item type for the
// multichannel biquad low-pass; no dependencies
`default_nettype none

package mbl_pkg;

  // channel count and field widths
  localparam int CHANNELS   = 16;
  localparam int CHAN_W     = 4;
  localparam int SAMPLE_W   = 9;
  localparam int CH_IDX_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // configuration registers
  localparam int GAIN_W     = 12;
  localparam int FB1_W      = 10;
  localparam int FB2_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(36);
  localparam logic [FB1_W-1:0]  FB1_RST  = FB1_W'(440);
  localparam logic [FB2_W-1:0]  FB2_RST  = FB2_W'(193);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN = 2'd0,
    REG_FB1  = 2'd1,
    REG_FB2  = 2'd2
  } cfg_reg_e;

  // datapath widths
  localparam int Y_W     = 20;                // signed q.8 output history
  localparam int SUM_W   = SAMPLE_W + 2;      // x + 2*x1 + x2
  localparam int MUL_A_W = GAIN_W + 1;        // coefficient, signed view
  localparam int MUL_B_W = Y_W + 1;           // history operand, signed
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 32;
  localparam int WHOLE_W = Y_W - 8;

  // queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = QPTR_W + 1;

  // one classified sample word
  typedef struct packed {
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample;
    logic                ch_ok;
  } item_t;

endpackage

`default_nettype wire

@@ rtl/core/mbl_if.sv @@
// mbl_in_if and mbl_out_if: valid/ready channels for sample words and
// filtered words; depends on mbl_pkg
`default_nettype none

interface mbl_in_if;
  logic                         valid;
  logic                         ready;
  logic [mbl_pkg::CHAN_W-1:0]   channel;
  logic [mbl_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

interface mbl_out_if;
  logic                         valid;
  logic                         ready;
  logic [mbl_pkg::CHAN_W-1:0]   channel_out;
  logic [mbl_pkg::SAMPLE_W-1:0] filtered;

  modport source (output valid, output channel_out, output filtered, input ready);
  modport sink   (input valid, input channel_out, input filtered, output ready);
endinterface

`default_nettype wire

@@ rtl/core/multichannel_biquad_lowpass.sv @@
// multichannel_biquad_lowpass: top level joining the front stage, the word
// queue and the filter back end; depends on mbl_pkg, mbl_if and submodules
// an accepted word passes the front register, the queue, the back end states
//   up to S_WB and the output register; the sequencer takes a word only in
//   S_IDLE and runs the three products of a word through one shared multiplier
// the input keeps accepting while the back end works, up to 5 words buffered
// reset: async active low; clears all channel histories and loads default gains
`default_nettype none

module multichannel_biquad_lowpass (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mbl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mbl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mbl_in_if.sink                              in_i,
  mbl_out_if.source                           out_o
);
  import mbl_pkg::*;

  item_t push_item;
  logic  push_valid;
  logic  push_ready;
  item_t pop_item;
  logic  pop_valid;
  logic  pop;

  // accept and classify
  mbl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_item_o  (push_item),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  // decoupling queue
  mbl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (push_item),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_item_o   (pop_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop)
  );

  // filter back end
  mbl_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .q_item_i   (pop_item),
    .q_valid_i  (pop_valid),
    .q_pop_o    (pop),
    .out_o      (out_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/mbl_front.sv @@
// mbl_front: input register stage that accepts sample words and classifies
// the channel number; depends on mbl_pkg and mbl_in_if
`default_nettype none

module mbl_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  mbl_in_if.sink             in_i,
  output mbl_pkg::item_t     push_item_o,
  output logic               push_valid_o,
  input  wire logic          push_ready_i
);
  import mbl_pkg::*;

  logic  valid_q;
  item_t item_q;
  item_t item_d;
  logic  take;

  // stage is free when empty or when its word moves on this cycle
  assign in_i.ready = !valid_q || push_ready_i;
  assign take       = in_i.valid && in_i.ready;

  // classify: channels beyond the table pass through without state access
  always_comb begin
    item_d.channel = in_i.channel;
    item_d.sample  = in_i.sample;
    item_d.ch_ok   = int'(in_i.channel) < CHANNELS;
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take) begin
      valid_q <= 1'b1;
    end else if (push_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign push_item_o  = item_q;
  assign push_valid_o = valid_q;

endmodule

`default_nettype wire

@@ rtl/core/mbl_queue.sv @@
// mbl_queue: short fifo of classified words between front and back
// depends on mbl_pkg
`default_nettype none

module mbl_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire mbl_pkg::item_t push_item_i,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  output mbl_pkg::item_t      pop_item_o,
  output logic                pop_valid_o,
  input  wire logic           pop_i
);
  import mbl_pkg::*;

  item_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              do_push;
  logic              do_pop;

  assign push_ready_o = count_q != QCNT_W'(QDEPTH);
  assign pop_valid_o  = count_q != '0;
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/mbl_back.sv @@
// mbl_back: coefficient registers, per-channel history and the filter
// sequencer with one shared multiplier; depends on mbl_pkg and mbl_out_if
`default_nettype none

module mbl_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [mbl_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [mbl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire mbl_pkg::item_t                 q_item_i,
  input  wire logic                           q_valid_i,
  output logic                                q_pop_o,
  mbl_out_if.source                           out_o
);
  import mbl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_SUM,
    S_MUL_Y1,
    S_MUL_Y2,
    S_SUB,
    S_WB
  } state_e;

  localparam logic signed [ACC_W-1:0] Y_MAX_A = ACC_W'(2 ** (Y_W - 1) - 1);
  localparam logic signed [ACC_W-1:0] Y_MIN_A = -ACC_W'(2 ** (Y_W - 1));
  localparam logic signed [WHOLE_W-1:0] OUT_MAX =
    WHOLE_W'(2 ** SAMPLE_W - 1);

  // coefficient registers
  logic [GAIN_W-1:0] gain_q;
  logic [FB1_W-1:0]  fb1_q;
  logic [FB2_W-1:0]  fb2_q;

  // per-channel history
  logic [SAMPLE_W-1:0]   hx1_q [CHANNELS];
  logic [SAMPLE_W-1:0]   hx2_q [CHANNELS];
  logic signed [Y_W-1:0] hy1_q [CHANNELS];
  logic signed [Y_W-1:0] hy2_q [CHANNELS];

  // working registers of the current word
  state_e                state_q;
  logic [CHAN_W-1:0]     ch_q;
  logic                  ok_q;
  logic [CH_IDX_W-1:0]   idx_q;
  logic [SAMPLE_W-1:0]   x_q;
  logic [SAMPLE_W-1:0]   x1_q;
  logic [SAMPLE_W-1:0]   x2_q;
  logic signed [Y_W-1:0] y1_q;
  logic signed [Y_W-1:0] y2_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;

  // output register
  logic                  ovalid_q;
  logic [CHAN_W-1:0]     ochan_q;
  logic [SAMPLE_W-1:0]   ofilt_q;

  logic [CH_IDX_W-1:0]      q_idx;
  logic [SUM_W-1:0]         tap_sum;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_c;
  logic signed [ACC_W-1:0]   y_full;
  logic signed [Y_W-1:0]     y_sat;
  logic signed [WHOLE_W-1:0] whole;
  logic [SAMPLE_W-1:0]       filt_c;
  logic                      out_free;
  logic                      wb_fire;

  assign q_idx    = CH_IDX_W'(q_item_i.channel);
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;
  assign out_free = !ovalid_q || out_o.ready;
  assign wb_fire  = (state_q == S_WB) && out_free;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RST;
      fb1_q  <= FB1_RST;
      fb2_q  <= FB2_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GAIN: gain_q <= cfg_data_i[GAIN_W-1:0];
        REG_FB1:  fb1_q  <= cfg_data_i[FB1_W-1:0];
        REG_FB2:  fb2_q  <= cfg_data_i[FB2_W-1:0];
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  assign tap_sum = SUM_W'(x_q) + (SUM_W'(x1_q) << 1) + SUM_W'(x2_q);

  always_comb begin
    unique case (state_q)
      S_MUL_Y1: begin
        mul_a = $signed(MUL_A_W'(fb1_q));
        mul_b = MUL_B_W'(y1_q);
      end
      S_MUL_Y2: begin
        mul_a = $signed(MUL_A_W'(fb2_q));
        mul_b = MUL_B_W'(y2_q);
      end
      default: begin
        mul_a = $signed(MUL_A_W'(gain_q));
        mul_b = $signed(MUL_B_W'(tap_sum));
      end
    endcase
  end

  assign prod_c = mul_a * mul_b;

  // floor by 256, saturate the state, clamp the integer part
  always_comb begin
    y_full = acc_q >>> 8;
    if (y_full > Y_MAX_A) begin
      y_sat = Y_W'(Y_MAX_A);
    end else if (y_full < Y_MIN_A) begin
      y_sat = Y_W'(Y_MIN_A);
    end else begin
      y_sat = Y_W'(y_full);
    end
    whole = WHOLE_W'(y_sat >>> 8);
    if (!ok_q || whole < 0) begin
      filt_c = '0;
    end else if (whole > OUT_MAX) begin
      filt_c = SAMPLE_W'(OUT_MAX);
    end else begin
      filt_c = SAMPLE_W'(whole);
    end
  end

  // sequencer, multiply-accumulate and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      if (wb_fire) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            state_q <= q_item_i.ch_ok ? S_MUL_SUM : S_WB;
          end
        end
        S_MUL_SUM: state_q <= S_MUL_Y1;
        S_MUL_Y1:  state_q <= S_MUL_Y2;
        S_MUL_Y2:  state_q <= S_SUB;
        S_SUB:     state_q <= S_WB;
        S_WB: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default:   state_q <= S_IDLE;
      endcase
    end
  end

  // datapath registers of the current word
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      ch_q  <= q_item_i.channel;
      ok_q  <= q_item_i.ch_ok;
      idx_q <= q_idx;
      x_q   <= q_item_i.sample;
      if (q_item_i.ch_ok) begin
        x1_q <= hx1_q[q_idx];
        x2_q <= hx2_q[q_idx];
        y1_q <= hy1_q[q_idx];
        y2_q <= hy2_q[q_idx];
      end
    end
    prod_q <= prod_c;
    if (state_q == S_MUL_Y1) begin
      acc_q <= ACC_W'(prod_q) <<< 4;
    end else if (state_q == S_MUL_Y2) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end else if (state_q == S_SUB) begin
      acc_q <= acc_q - ACC_W'(prod_q);
    end
    if (wb_fire) begin
      ochan_q <= ch_q;
      ofilt_q <= filt_c;
    end
  end

  // history update at write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        hx1_q[i] <= '0;
        hx2_q[i] <= '0;
        hy1_q[i] <= '0;
        hy2_q[i] <= '0;
      end
    end else if (wb_fire && ok_q) begin
      hx2_q[idx_q] <= x1_q;
      hx1_q[idx_q] <= x_q;
      hy2_q[idx_q] <= y1_q;
      hy1_q[idx_q] <= y_sat;
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.channel_out = ochan_q;
  assign out_o.filtered    = ofilt_q;

endmodule

`default_nettype wire

@@ rtl/core/mbl_checker.sv @@
// mbl_checker: port-level assertions for multichannel_biquad_lowpass and the
// bind that attaches them; depends on mbl_pkg
`default_nettype none

module mbl_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_i,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic [mbl_pkg::CHAN_W-1:0]   out_channel_i,
  input wire logic [mbl_pkg::SAMPLE_W-1:0] out_filtered_i
);
  import mbl_pkg::*;

  localparam int CAP   = QDEPTH + 3;
  localparam int CNT_W = $clog2(CAP + 1) + 1;

  logic [CNT_W-1:0] pend_q;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // words accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 1'b1;
    end
  end

  // a result is only shown for a word already taken
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> pend_q != '0)
    else $error("output word without a pending input word");

  // buffering never exceeds the pipeline capacity
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> pend_q < CNT_W'(CAP))
    else $error("input accepted beyond pipeline capacity");

  // out-of-range channels report zero
  a_bad_channel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && int'(out_channel_i) >= CHANNELS) |-> out_filtered_i == '0)
    else $error("nonzero result for channel outside the table");

  // a stalled result stays offered and unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_channel_i) && $stable(out_filtered_i)))
    else $error("stalled output word dropped or changed");

endmodule

bind multichannel_biquad_lowpass mbl_checker u_mbl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_channel_i  (out_o.channel_out),
  .out_filtered_i (out_o.filtered)
);

`default_nettype wire
